// ===== rtl/core/stsd_pkg.sv =====
// Package for the degree-input Taylor sine: shared types, widths and constants.
package stsd_pkg;

  // Field widths of the ports
  localparam int ANGLE_W = 16;
  localparam int TC_W    = 6;
  localparam int OUT_W   = 32;

  // Internal fixed point: magnitudes in Q.40
  localparam int FRAC    = 40;
  localparam int MAG_W   = 52;
  localparam int HALF_W  = MAG_W / 2;
  localparam int ACC_W   = 2 * MAG_W;
  localparam int PROD_W  = 60;
  localparam int SUM_W   = 56;

  // Divider: bits retired per cycle and resulting pass count
  localparam int DIV_BITS  = 4;
  localparam int DIV_STEPS = PROD_W / DIV_BITS;

  // Degree to radian conversion: x = angle * pi * 2^40 / (180 * 128)
  localparam logic [41:0] PI_Q40    = 42'h3243F6A8886;
  localparam int          DEG_SCALE = 23040;
  localparam int          DEG_HALF  = DEG_SCALE / 2;

  // Degree scale is 45 * 2^9: shift out 2^9, then divide by 45 as a product
  // with ceil(2^54 / 45), exact for every dividend below 2^48
  localparam int               DEG_PRE_SHIFT = 9;
  localparam int               RCP_SHIFT     = 54;
  localparam logic [MAG_W-1:0] DEG_RCP       = 52'd400319966877378;

  // First series divisor (2n)(2n+1) at n = 1, and its step offset 8n + 6
  localparam int FIRST_DIVISOR = 6;
  localparam int DIVISOR_STEP  = 6;

  // Output rounding from Q.40 to Q.30 and saturation to one
  localparam int              OUT_SHIFT = FRAC - 30;
  localparam logic [OUT_W-1:0] Q30_ONE  = 32'h4000_0000;

  localparam logic [TC_W-1:0] TERM_COUNT_RESET = 6'd12;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CONV_MUL,
    ST_CONV_DIV,
    ST_SQ_MUL,
    ST_TERM_CHK,
    ST_TERM_MUL,
    ST_TERM_DIV
  } stsd_state_e;

  // Multiplier output forms: raw product, Q.40 rounded, reciprocal quotient
  typedef enum logic [1:0] {
    MUL_RAW,
    MUL_Q40,
    MUL_RCP
  } stsd_mul_mode_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;      // latch angle, start angle * pi product
    logic conv_div;  // start reciprocal product for the degree scale
    logic square;    // latch x, start x * x
    logic init;      // latch x^2, seed term and sum
    logic term_mul;  // start term * x^2
    logic term_div;  // start division by (2n)(2n+1)
    logic accum;     // take new term, add to sum, advance n
    logic emit;      // round, saturate and present the result
  } stsd_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic last_term;
  } stsd_stat_t;

endpackage

// ===== rtl/core/stsd_mul.sv =====
// Iterative 52x52 magnitude multiplier, one 26x26 partial product per cycle.
module stsd_mul (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  stsd_pkg::stsd_mul_mode_e        mode_i,
  input  logic [stsd_pkg::MAG_W-1:0]      a_i,
  input  logic [stsd_pkg::MAG_W-1:0]      b_i,
  output logic [stsd_pkg::PROD_W-1:0]     prod_o,
  output logic                            done_o
);
  import stsd_pkg::*;

  logic [MAG_W-1:0]  a_q, b_q;
  stsd_mul_mode_e    mode_q;
  logic [ACC_W-1:0]  acc_q, acc_d;
  logic [1:0]        step_q;
  logic              run_q, done_q;
  logic [HALF_W-1:0] a_half, b_half;
  logic [MAG_W-1:0]  pp;
  logic [ACC_W-1:0]  pp_ext, pp_sh, rnd;

  // Pick the operand halves for this pass and place the partial product
  always_comb begin
    a_half = step_q[1] ? a_q[MAG_W-1:HALF_W] : a_q[HALF_W-1:0];
    b_half = step_q[0] ? b_q[MAG_W-1:HALF_W] : b_q[HALF_W-1:0];
    pp     = MAG_W'(a_half) * MAG_W'(b_half);
    pp_ext = ACC_W'(pp);
    case (step_q)
      2'd0:    pp_sh = pp_ext;
      2'd1:    pp_sh = pp_ext << HALF_W;
      2'd2:    pp_sh = pp_ext << HALF_W;
      2'd3:    pp_sh = pp_ext << MAG_W;
      default: pp_sh = pp_ext;
    endcase
    acc_d = acc_q + pp_sh;
  end

  // Control: four passes, then a done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= 2'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q  <= 1'b1;
        step_q <= 2'd0;
      end else if (run_q) begin
        step_q <= step_q + 2'd1;
        if (step_q == 2'd3) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Operands and accumulator
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q    <= a_i;
      b_q    <= b_i;
      mode_q <= mode_i;
      acc_q  <= '0;
    end else if (run_q) begin
      acc_q <= acc_d;
    end
  end

  // Raw product, Q.40 product rounded half away from zero, or reciprocal quotient
  assign rnd = acc_q + (ACC_W'(1) << (FRAC - 1));

  always_comb begin
    case (mode_q)
      MUL_RAW: prod_o = acc_q[PROD_W-1:0];
      MUL_Q40: prod_o = rnd[FRAC +: PROD_W];
      MUL_RCP: prod_o = PROD_W'(acc_q[ACC_W-1:RCP_SHIFT]);
      default: prod_o = acc_q[PROD_W-1:0];
    endcase
  end

  assign done_o = done_q;

endmodule

// ===== rtl/core/stsd_div.sv =====
// Restoring divider for a narrow divisor, four quotient bits per cycle.
module stsd_div #(
  parameter int DVW = 15
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [stsd_pkg::PROD_W-1:0] dividend_i,
  input  logic [DVW-1:0]              divisor_i,
  output logic [stsd_pkg::PROD_W-1:0] quotient_o,
  output logic                        done_o
);
  import stsd_pkg::*;

  localparam int CNT_W = $clog2(DIV_STEPS);

  logic [PROD_W-1:0] quo_q, quo_d;
  logic [DVW-1:0]    rem_q, rem_d, dvs_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              run_q, done_q;

  // Retire four dividend bits: shift in, compare, subtract
  always_comb begin
    logic [DVW:0] trial;
    quo_d = quo_q;
    rem_d = rem_q;
    for (int k = 0; k < DIV_BITS; k++) begin
      trial = {rem_d, quo_d[PROD_W-1]};
      quo_d = {quo_d[PROD_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs_q}) begin
        trial    = trial - {1'b0, dvs_q};
        quo_d[0] = 1'b1;
      end
      rem_d = trial[DVW-1:0];
    end
  end

  // Control: fixed pass count, then a done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Dividend/quotient shift register and partial remainder
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (run_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

endmodule

// ===== rtl/core/stsd_datapath.sv =====
// Datapath: term count register, conversion, series recurrence and output rounding.
module stsd_datapath #(
  parameter int MAX_TERMS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  stsd_pkg::stsd_cmd_t           cmd_i,
  output stsd_pkg::stsd_stat_t          stat_o,
  input  logic signed [stsd_pkg::ANGLE_W-1:0] angle_deg_i,
  input  logic                          cfg_we_i,
  input  logic [stsd_pkg::TC_W-1:0]     term_count_i,
  output logic signed [stsd_pkg::OUT_W-1:0]   sine_value_o,
  output logic                          done_o
);
  import stsd_pkg::*;

  localparam int CW   = $clog2(MAX_TERMS + 1);
  localparam int DVW  = 2 * CW + 2;
  localparam int CMPW = ((CW > TC_W) ? CW : TC_W) + 1;

  logic [TC_W-1:0]         tc_q;
  logic [CW-1:0]           cnt_q, cnt_d, n_q;
  logic                    x_neg_q, term_neg_q;
  logic [MAG_W-1:0]        x_q, x2_q, term_q;
  logic signed [SUM_W-1:0] sum_q;
  logic [DVW-1:0]          dvs_q;
  logic [OUT_W-1:0]        res_q, res_d;
  logic                    done_q;

  logic [ANGLE_W-1:0]      ang_mag;
  logic                    mul_start, mul_done;
  stsd_mul_mode_e          mul_mode;
  logic [MAG_W-1:0]        mul_a, mul_b;
  logic [PROD_W-1:0]       mul_p;
  logic                    div_start, div_done;
  logic [PROD_W-1:0]       div_num, div_quo;
  logic [DVW-1:0]          div_dvs;
  logic [MAG_W-1:0]        quo_mag;
  logic signed [SUM_W-1:0] x_ext, q_ext;
  logic [SUM_W-1:0]        sum_mag, sum_rnd;
  logic [OUT_W-1:0]        sat_mag;

  // Term count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tc_q <= TERM_COUNT_RESET;
    end else if (cfg_we_i) begin
      tc_q <= term_count_i;
    end
  end

  // Clamp the term count to 1..MAX_TERMS
  always_comb begin
    if (tc_q == '0) begin
      cnt_d = CW'(1);
    end else if (CMPW'(tc_q) > CMPW'(MAX_TERMS)) begin
      cnt_d = CW'(MAX_TERMS);
    end else begin
      cnt_d = CW'(tc_q);
    end
  end

  // Angle magnitude; the most negative code maps to 2^15
  assign ang_mag = angle_deg_i[ANGLE_W-1] ? ANGLE_W'(-angle_deg_i) : ANGLE_W'(angle_deg_i);
  assign quo_mag = div_quo[MAG_W-1:0];

  // Multiplier operand select; the degree scale is a reciprocal product
  always_comb begin
    mul_start = cmd_i.load | cmd_i.conv_div | cmd_i.square | cmd_i.term_mul;
    if (cmd_i.load) begin
      mul_mode = MUL_RAW;
      mul_a    = MAG_W'(ang_mag);
      mul_b    = MAG_W'(PI_Q40);
    end else if (cmd_i.conv_div) begin
      mul_mode = MUL_RCP;
      mul_a    = MAG_W'((mul_p + PROD_W'(DEG_HALF)) >> DEG_PRE_SHIFT);
      mul_b    = DEG_RCP;
    end else if (cmd_i.square) begin
      mul_mode = MUL_Q40;
      mul_a    = mul_p[MAG_W-1:0];
      mul_b    = mul_p[MAG_W-1:0];
    end else begin
      mul_mode = MUL_Q40;
      mul_a    = term_q;
      mul_b    = x2_q;
    end
  end

  // Divider operands; the half divisor gives rounding to nearest
  assign div_start = cmd_i.term_div;
  assign div_num   = mul_p + PROD_W'(dvs_q >> 1);
  assign div_dvs   = dvs_q;

  stsd_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .mode_i  (mul_mode),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .prod_o  (mul_p),
    .done_o  (mul_done)
  );

  stsd_div #(
    .DVW (DVW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (div_dvs),
    .quotient_o (div_quo),
    .done_o     (div_done)
  );

  assign x_ext = SUM_W'(x_q);
  assign q_ext = SUM_W'(quo_mag);

  // Series registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_neg_q <= angle_deg_i[ANGLE_W-1];
      cnt_q   <= cnt_d;
    end
    if (cmd_i.square) begin
      x_q <= mul_p[MAG_W-1:0];
    end
    if (cmd_i.init) begin
      x2_q       <= mul_p[MAG_W-1:0];
      term_q     <= x_q;
      term_neg_q <= x_neg_q;
      sum_q      <= x_neg_q ? -x_ext : x_ext;
      n_q        <= CW'(1);
      dvs_q      <= DVW'(FIRST_DIVISOR);
    end
    // Each new term flips sign; next divisor is (2n+2)(2n+3)
    if (cmd_i.accum) begin
      term_q     <= quo_mag;
      term_neg_q <= !term_neg_q;
      sum_q      <= term_neg_q ? sum_q + q_ext : sum_q - q_ext;
      n_q        <= n_q + CW'(1);
      dvs_q      <= dvs_q + DVW'({n_q, 3'b000}) + DVW'(DIVISOR_STEP);
    end
    if (cmd_i.emit) begin
      res_q <= res_d;
    end
  end

  // Round Q.40 to Q.30 and saturate to one
  always_comb begin
    sum_mag = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
    sum_rnd = (sum_mag + (SUM_W'(1) << (OUT_SHIFT - 1))) >> OUT_SHIFT;
    sat_mag = (sum_rnd > SUM_W'(Q30_ONE)) ? Q30_ONE : sum_rnd[OUT_W-1:0];
    res_d   = sum_q[SUM_W-1] ? -sat_mag : sat_mag;
  end

  // Result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.emit;
    end
  end

  assign stat_o.mul_done  = mul_done;
  assign stat_o.div_done  = div_done;
  assign stat_o.last_term = (n_q >= cnt_q);
  assign sine_value_o     = res_q;
  assign done_o           = done_q;

endmodule

// ===== rtl/core/stsd_ctrl.sv =====
// Controller: sequences conversion, squaring and the per-term multiply and divide.
module stsd_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  stsd_pkg::stsd_stat_t stat_i,
  output stsd_pkg::stsd_cmd_t  cmd_o,
  output logic                 busy_o
);
  import stsd_pkg::*;

  stsd_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CONV_MUL;
        end
      end
      ST_CONV_MUL: begin
        if (stat_i.mul_done) begin
          cmd_o.conv_div = 1'b1;
          state_d        = ST_CONV_DIV;
        end
      end
      // Degree scale runs as a reciprocal product on the multiplier
      ST_CONV_DIV: begin
        if (stat_i.mul_done) begin
          cmd_o.square = 1'b1;
          state_d      = ST_SQ_MUL;
        end
      end
      ST_SQ_MUL: begin
        if (stat_i.mul_done) begin
          cmd_o.init = 1'b1;
          state_d    = ST_TERM_CHK;
        end
      end
      ST_TERM_CHK: begin
        if (stat_i.last_term) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end else begin
          cmd_o.term_mul = 1'b1;
          state_d        = ST_TERM_MUL;
        end
      end
      ST_TERM_MUL: begin
        if (stat_i.mul_done) begin
          cmd_o.term_div = 1'b1;
          state_d        = ST_TERM_DIV;
        end
      end
      ST_TERM_DIV: begin
        if (stat_i.div_done) begin
          cmd_o.accum = 1'b1;
          state_d     = ST_TERM_CHK;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

// ===== rtl/core/sine_taylor_series_degrees.sv =====
// Top level: sine of an angle in degrees by a truncated Taylor series.
//
//   channel   signals                          direction     handshake
//   ------    -------------------------------  ------------  --------------------------
//   command   start, busy, angle_deg_i         in, busy out  start & !busy takes a word
//   result    done_o, sine_value_o             out           one-cycle strobe, no stall
//   config    valid, ready, term_count_i       in, ready out valid & ready writes
//
// One angle runs the angle product, the reciprocal product for the degree
// scale and the square on the shared 26x26 multiplier; each further term, up to
// the clamped term count, costs four multiplier passes and fifteen passes of the
// radix-16 divider.
// Reset (rst_ni low, asynchronous) returns the controller to idle and the term
// count to 12. The result strobe cannot be held off; busy falls in the cycle
// the strobe rises, so the next word can be taken alongside it.
module sine_taylor_series_degrees #(
  parameter int MAX_TERMS = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [stsd_pkg::ANGLE_W-1:0] angle_deg_i,
  output logic                                done_o,
  output logic signed [stsd_pkg::OUT_W-1:0]   sine_value_o,
  input  logic                                valid,
  output logic                                ready,
  input  logic [stsd_pkg::TC_W-1:0]           term_count_i
);
  import stsd_pkg::*;

  stsd_cmd_t  cmd;
  stsd_stat_t stat;
  logic       cfg_we;

  // Config writes are always taken
  assign ready  = 1'b1;
  assign cfg_we = valid & ready;

  stsd_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  stsd_datapath #(
    .MAX_TERMS (MAX_TERMS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .angle_deg_i  (angle_deg_i),
    .cfg_we_i     (cfg_we),
    .term_count_i (term_count_i),
    .sine_value_o (sine_value_o),
    .done_o       (done_o)
  );

endmodule

// ===== tb/sine_taylor_series_degrees_tb.sv =====
// Testbench for the degree-input Taylor sine: directed angle table, then random phases.
module sine_taylor_series_degrees_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import stsd_pkg::*;

  localparam int MAX_TERMS   = 32;
  localparam int HALF_PERIOD = 6;
  localparam int RESET_CYCLES = 7;
  // Slowest angle: a run at MAX_TERMS terms, from start to strobe
  localparam int SLOWEST_ANGLE = 17 + 22 * (MAX_TERMS - 1);
  localparam int TAIL_CYCLES   = SLOWEST_ANGLE + 10;
  localparam int QUIET_LIMIT   = 6 * SLOWEST_ANGLE;
  localparam int NUM_PHASES    = 10;

  // One directed word: term count to run it under, angle, optional typed-in sine
  typedef struct packed {
    logic [TC_W-1:0]           terms;
    logic signed [ANGLE_W-1:0] angle;
    logic                      known;
    logic signed [OUT_W-1:0]   sine;
  } angle_row_t;

  localparam int NUM_ROWS = 25;
  localparam angle_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    '{6'd12, 16'sd0,      1'b1, 32'sd0},
    '{6'd12, 16'sd11520,  1'b1, Q30_ONE},
    '{6'd12, -16'sd11520, 1'b1, -Q30_ONE},
    '{6'd12, 16'sd23040,  1'b0, 32'sd0},
    '{6'd12, -16'sd23040, 1'b0, 32'sd0},
    '{6'd12, 16'sd23041,  1'b0, 32'sd0},
    '{6'd12, -16'sd23041, 1'b0, 32'sd0},
    '{6'd12, 16'sd32767,  1'b0, 32'sd0},
    '{6'd12, -16'sd32768, 1'b0, 32'sd0},
    '{6'd12, 16'sd1,      1'b0, 32'sd0},
    '{6'd12, -16'sd1,     1'b0, 32'sd0},
    '{6'd12, 16'sd21845,  1'b0, 32'sd0},
    '{6'd12, -16'sd21846, 1'b0, 32'sd0},
    '{6'd1,  16'sd11520,  1'b1, Q30_ONE},
    '{6'd1,  -16'sd11520, 1'b1, -Q30_ONE},
    '{6'd1,  16'sd0,      1'b1, 32'sd0},
    '{6'd1,  16'sd7680,   1'b1, Q30_ONE},
    '{6'd0,  16'sd11520,  1'b1, Q30_ONE},
    '{6'd0,  16'sd1000,   1'b0, 32'sd0},
    '{6'd63, 16'sd3840,   1'b0, 32'sd0},
    '{6'd63, -16'sd32768, 1'b0, 32'sd0},
    '{6'd32, 16'sd32767,  1'b0, 32'sd0},
    '{6'd32, -16'sd15360, 1'b0, 32'sd0},
    '{6'd2,  16'sd23040,  1'b0, 32'sd0},
    '{6'd33, 16'sd11520,  1'b1, Q30_ONE}
  };

  // Term count per random phase; clamped counts above 16 get fewer words
  localparam logic [TC_W-1:0] PHASE_TERMS [NUM_PHASES] = '{
    6'd1, 6'd32, 6'd0, 6'd63, 6'd5, 6'd2, 6'd20, 6'd40, 6'd8, 6'd12
  };

  logic                      clk_i;
  logic                      rst_ni;
  logic                      start;
  logic                      busy;
  logic signed [ANGLE_W-1:0] angle_deg_i;
  logic                      done_o;
  logic signed [OUT_W-1:0]   sine_value_o;
  logic                      valid;
  logic                      ready;
  logic [TC_W-1:0]           term_count_i;

  logic signed [OUT_W-1:0] expected_sines [$];
  logic [TC_W-1:0]         term_setting;
  int                      failures;
  int                      quiet_cycles;

  sine_taylor_series_degrees #(
    .MAX_TERMS(MAX_TERMS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .angle_deg_i (angle_deg_i),
    .done_o      (done_o),
    .sine_value_o(sine_value_o),
    .valid       (valid),
    .ready       (ready),
    .term_count_i(term_count_i)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // Signed division by a positive divisor, rounded to nearest, ties away from zero
  function automatic longint div_nearest(input longint num, input longint unsigned den);
    longint unsigned mag;
    longint unsigned quo;
    mag = (num < 0) ? longint'(-num) : longint'(num);
    quo = (mag + den / 2) / den;
    return (num < 0) ? -longint'(quo) : longint'(quo);
  endfunction

  // Q.40 product, exact then rounded to nearest, ties away from zero
  function automatic longint mul_q40_nearest(input longint a, input longint b);
    longint unsigned ua;
    longint unsigned ub;
    logic [127:0]    prod;
    longint unsigned mag;
    ua   = (a < 0) ? longint'(-a) : longint'(a);
    ub   = (b < 0) ? longint'(-b) : longint'(b);
    prod = {64'd0, ua} * {64'd0, ub} + (128'd1 << (FRAC - 1));
    mag  = prod[FRAC+63:FRAC];
    return ((a < 0) != (b < 0)) ? -longint'(mag) : longint'(mag);
  endfunction

  // Sine in Q1.30 of an angle in 1/128 degree, summed over the given term count
  function automatic logic signed [OUT_W-1:0] taylor_sine(
    input logic signed [ANGLE_W-1:0] angle,
    input logic [TC_W-1:0]           terms
  );
    longint          rad;
    longint          rad_sq;
    longint          term;
    longint          acc;
    longint unsigned mag;
    int              count;
    int              n;
    logic [OUT_W-1:0] res;
    count = (terms < 1) ? 1 : (terms > MAX_TERMS) ? MAX_TERMS : int'(terms);
    rad    = div_nearest(longint'(angle) * longint'(PI_Q40), DEG_SCALE);
    rad_sq = mul_q40_nearest(rad, rad);
    term   = rad;
    acc    = rad;
    for (n = 1; n < count; n++) begin
      term = -div_nearest(mul_q40_nearest(term, rad_sq), longint'((2 * n) * (2 * n + 1)));
      acc  = acc + term;
    end
    // Round Q.40 down to Q.30 and clamp to one
    mag = (acc < 0) ? longint'(-acc) : longint'(acc);
    mag = (mag + (64'd1 << (OUT_SHIFT - 1))) >> OUT_SHIFT;
    if (mag > 64'(Q30_ONE)) begin
      mag = 64'(Q30_ONE);
    end
    res = mag[OUT_W-1:0];
    return (acc < 0) ? -res : res;
  endfunction

  // Offer one angle word, hold it until taken, and queue its expected sine
  task automatic send_angle(input logic signed [ANGLE_W-1:0] angle, input logic known,
                            input logic signed [OUT_W-1:0] sine);
    start       <= 1'b1;
    angle_deg_i <= angle;
    @(posedge clk_i);
    while (busy) begin
      @(posedge clk_i);
    end
    expected_sines.push_back(known ? sine : taylor_sine(angle, term_setting));
  endtask

  // Drop start for a burst of idle cycles
  task automatic idle_burst(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Drop start and wait until every queued sine has come back
  task automatic drain_sines();
    start <= 1'b0;
    while (expected_sines.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Write the term count register while the block is idle
  task automatic write_term_count(input logic [TC_W-1:0] terms);
    valid        <= 1'b1;
    term_count_i <= terms;
    @(posedge clk_i);
    while (!ready) begin
      @(posedge clk_i);
    end
    term_setting = terms;
    valid <= 1'b0;
  endtask

  // Check each result strobe against the oldest expected sine; watch for a hang
  always @(posedge clk_i) begin
    logic signed [OUT_W-1:0] want;
    if (rst_ni) begin
      if (done_o === 1'b1) begin
        if (expected_sines.size() == 0) begin
          $error("sine_value: no word expected, got %0d", sine_value_o);
          failures++;
        end else begin
          want = expected_sines.pop_front();
          if (sine_value_o !== want) begin
            $error("sine_value: expected %0d, got %0d", want, sine_value_o);
            failures++;
          end
        end
      end
      if ((start && !busy) || done_o === 1'b1 || (valid && ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    logic signed [ANGLE_W-1:0] angle;
    int                        words;
    bit                        may_idle;
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    start        = 1'b0;
    angle_deg_i  = '0;
    valid        = 1'b0;
    term_count_i = '0;
    failures     = 0;
    quiet_cycles = 0;
    term_setting = TERM_COUNT_RESET;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table: change the term count only between drained groups
    for (int r = 0; r < NUM_ROWS; r++) begin
      if (DIRECTED_ROWS[r].terms != term_setting) begin
        drain_sines();
        write_term_count(DIRECTED_ROWS[r].terms);
      end
      send_angle(DIRECTED_ROWS[r].angle, DIRECTED_ROWS[r].known, DIRECTED_ROWS[r].sine);
    end

    // Random phases, each under its own term count
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_sines();
      write_term_count(PHASE_TERMS[p]);
      words    = (PHASE_TERMS[p] > 6'd16) ? 25 : 95;
      may_idle = (p < NUM_PHASES - 2) && (p % 3 != 1);
      for (int i = 0; i < words; i++) begin
        case ($urandom_range(0, 9))
          0:       angle = ANGLE_W'($urandom);
          1:       angle = ANGLE_W'($urandom_range(0, 64) - 32);
          default: angle = ANGLE_W'($urandom_range(0, 2 * DEG_SCALE) - DEG_SCALE);
        endcase
        send_angle(angle, 1'b0, '0);
        if (may_idle && $urandom_range(0, 2) == 0) begin
          idle_burst($urandom_range(1, 10));
        end
      end
    end

    // Let the last sines come back, then allow one slowest angle more
    drain_sines();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (expected_sines.size() != 0) begin
      $error("sine_value: %0d expected words never arrived", expected_sines.size());
      failures++;
    end
    if (failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/stsd_pkg.sv
rtl/core/stsd_mul.sv
rtl/core/stsd_div.sv
rtl/core/stsd_datapath.sv
rtl/core/stsd_ctrl.sv
rtl/core/sine_taylor_series_degrees.sv
tb/sine_taylor_series_degrees_tb.sv
